### design/qipd_pkg.sv
// Package with the shared types and constants of the QUIC Initial packet detector.
`timescale 1ns / 1ps

package qipd_pkg;

  localparam int unsigned MaxDcidLen = 20;
  localparam int unsigned CountMax   = 31;
  localparam int unsigned CountW     = 5;
  localparam int unsigned LenCheckW  = 9;

  localparam logic [7:0] HdrFormFixed = 8'hC0;
  localparam logic [1:0] TypeInitialV1 = 2'b00;
  localparam logic [1:0] TypeInitialV2 = 2'b01;

  localparam logic [CountW-1:0] IdxFirst  = CountW'(0);
  localparam logic [CountW-1:0] IdxVerLo  = CountW'(1);
  localparam logic [CountW-1:0] IdxVerHi  = CountW'(4);
  localparam logic [CountW-1:0] IdxDcid   = CountW'(5);
  localparam logic [CountW-1:0] CountSat  = CountW'(CountMax);

  // The fixed header bytes ahead of the connection ID plus the source ID length byte.
  localparam logic [LenCheckW-1:0] HdrOverhead = LenCheckW'(7);

  localparam logic [31:0] VersionV1      = 32'h0000_0001;
  localparam logic [31:0] VersionV2      = 32'h6b33_43cf;
  localparam logic [31:0] VersionDraft29 = 32'hff00_001d;
  localparam logic [31:0] VersionDraft32 = 32'hff00_0020;
  localparam logic [31:0] VersionDraft33 = 32'hff00_0021;
  localparam logic [31:0] VersionDraft34 = 32'hff00_0022;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindV1    = 2'd1,
    KindV2    = 2'd2,
    KindDraft = 2'd3
  } version_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       detected;
    logic [1:0] version_kind;
  } out_t;

  typedef struct packed {
    logic [7:0]        first_byte;
    logic [31:0]       version_word;
    logic [7:0]        dcid_length;
    logic [CountW-1:0] pkt_len;
  } hdr_t;

endpackage

### design/quic_initial_packet_detector.sv
// Top level of the QUIC Initial packet detector: header capture, byte count and result register.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (data_byte, last_byte)
// out      output     out_valid_o / out_stall_i  out_data_o (detected, version_kind)
//
// One byte is taken every cycle unless a last byte is stalled; the result of a payload
// appears in the output register in the cycle after its last byte is accepted.
// Bytes that are not the last are taken even while a result waits; a last byte
// stalls only while the output register is full and stalled.
// Reset clears the byte count, the captured header and the output valid flag.
`timescale 1ns / 1ps

module quic_initial_packet_detector (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  qipd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output qipd_pkg::out_t  out_data_o
);
  import qipd_pkg::*;

  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [7:0]        first_byte_q, first_byte_d;
  logic [31:0]       version_word_q, version_word_d;
  logic [7:0]        dcid_length_q, dcid_length_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;

  logic              in_accept;
  logic              last_accept;
  hdr_t              hdr;
  out_t              res;

  assign in_stall_o  = out_valid_q && out_stall_i && in_data_i.last_byte;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign last_accept = in_accept && in_data_i.last_byte;

  always_comb begin
    hdr.first_byte   = (byte_count_q == IdxFirst) ? in_data_i.data_byte : first_byte_q;
    hdr.version_word = (byte_count_q >= IdxVerLo && byte_count_q <= IdxVerHi) ?
                       {version_word_q[23:0], in_data_i.data_byte} : version_word_q;
    hdr.dcid_length  = (byte_count_q == IdxDcid) ? in_data_i.data_byte : dcid_length_q;
    hdr.pkt_len      = (byte_count_q < CountSat) ? byte_count_q + CountW'(1) : CountSat;
  end

  qipd_classify u_classify (
    .hdr_i (hdr),
    .res_o (res)
  );

  always_comb begin
    byte_count_d   = byte_count_q;
    first_byte_d   = first_byte_q;
    version_word_d = version_word_q;
    dcid_length_d  = dcid_length_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_data_d     = out_data_q;
    if (in_accept) begin
      if (in_data_i.last_byte) begin
        byte_count_d   = '0;
        first_byte_d   = '0;
        version_word_d = '0;
        dcid_length_d  = '0;
        out_valid_d    = 1'b1;
        out_data_d     = res;
      end else begin
        byte_count_d   = hdr.pkt_len;
        first_byte_d   = hdr.first_byte;
        version_word_d = hdr.version_word;
        dcid_length_d  = hdr.dcid_length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      first_byte_q   <= '0;
      version_word_q <= '0;
      dcid_length_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      byte_count_q   <= byte_count_d;
      first_byte_q   <= first_byte_d;
      version_word_q <= version_word_d;
      dcid_length_q  <= dcid_length_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A last byte always leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_accept |=> out_valid_o)
    else $error("Result missing after the last byte of a payload.");

  // The capture state starts over after every payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_accept |=> (byte_count_q == '0 && version_word_q == '0))
    else $error("Capture state not cleared after a payload.");

  // The byte count holds at its ceiling on long payloads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !in_data_i.last_byte && byte_count_q == CountSat) |=>
    byte_count_q == CountSat)
    else $error("Byte count left saturation.");

  // A payload that is not detected reports no version kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.detected) |-> out_data_o.version_kind == KindNone)
    else $error("Version kind set on an undetected payload.");

endmodule

### design/qipd_classify.sv
// Combinational header check that turns captured header fields into a detection result.
`timescale 1ns / 1ps

module qipd_classify (
  input  qipd_pkg::hdr_t hdr_i,
  output qipd_pkg::out_t res_o
);
  import qipd_pkg::*;

  version_kind_e kind;
  logic [1:0]    initial_bits;
  logic          form_ok;
  logic          type_ok;
  logic          dcid_ok;
  logic          len_ok;
  logic          ok;

  always_comb begin
    case (hdr_i.version_word)
      VersionV1: begin
        kind         = KindV1;
        initial_bits = TypeInitialV1;
      end
      VersionV2: begin
        kind         = KindV2;
        initial_bits = TypeInitialV2;
      end
      VersionDraft29, VersionDraft32, VersionDraft33, VersionDraft34: begin
        kind         = KindDraft;
        initial_bits = TypeInitialV1;
      end
      default: begin
        kind         = KindNone;
        initial_bits = TypeInitialV1;
      end
    endcase
  end

  assign form_ok = (hdr_i.first_byte & HdrFormFixed) == HdrFormFixed;
  assign type_ok = hdr_i.first_byte[5:4] == initial_bits;
  assign dcid_ok = hdr_i.dcid_length <= 8'(MaxDcidLen);
  assign len_ok  = LenCheckW'(hdr_i.pkt_len) >= (LenCheckW'(hdr_i.dcid_length) + HdrOverhead);
  assign ok      = form_ok && (kind != KindNone) && type_ok && dcid_ok && len_ok;

  assign res_o.detected     = ok;
  assign res_o.version_kind = ok ? kind : KindNone;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the QUIC Initial packet detector with stall and idle traffic.
`timescale 1ns / 1ps

module tb;
  import qipd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBytes = 90;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  out_t expected_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  int unsigned pkt_cnt = 0;
  logic [7:0] cap_first = '0;
  logic [31:0] cap_version = '0;
  logic [7:0] cap_dcid = '0;

  int unsigned max_gap = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  quic_initial_packet_detector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] known_version(input int unsigned sel);
    case (sel)
      0: return VersionV1;
      1: return VersionV2;
      2: return VersionDraft29;
      3: return VersionDraft32;
      4: return VersionDraft33;
      default: return VersionDraft34;
    endcase
  endfunction

  function automatic void predict_verdict(input logic [7:0] b, input logic last);
    int unsigned idx;
    int unsigned len;
    version_kind_e kind;
    logic [1:0] initial_bits;
    logic hit;
    out_t verdict;
    idx = pkt_cnt;
    if (idx == 0) begin
      cap_first = b;
    end else if (idx <= 4) begin
      cap_version = {cap_version[23:0], b};
    end else if (idx == 5) begin
      cap_dcid = b;
    end
    len = (idx < CountMax) ? idx + 1 : CountMax;
    if (!last) begin
      pkt_cnt = len;
      return;
    end
    initial_bits = TypeInitialV1;
    case (cap_version)
      VersionV1: kind = KindV1;
      VersionV2: begin
        kind = KindV2;
        initial_bits = TypeInitialV2;
      end
      VersionDraft29, VersionDraft32, VersionDraft33, VersionDraft34: kind = KindDraft;
      default: kind = KindNone;
    endcase
    hit = ((cap_first & HdrFormFixed) == HdrFormFixed) && (kind != KindNone)
        && (cap_first[5:4] == initial_bits) && (cap_dcid <= MaxDcidLen)
        && (len >= 7 + cap_dcid);
    verdict.detected = hit;
    verdict.version_kind = hit ? kind : KindNone;
    expected_verdicts.push_back(verdict);
    pkt_cnt = 0;
    cap_first = '0;
    cap_version = '0;
    cap_dcid = '0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("Mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid_i <= 1'b1;
    in_data_i <= {b, last};
    do @(posedge clk_i); while (in_stall_o);
    predict_verdict(b, last);
    bytes_sent++;
    @(negedge clk_i);
    if (max_gap != 0) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(negedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_payload(input logic [7:0] first, input logic [31:0] version,
                              input logic [7:0] dcid, input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (i)
        0: b = first;
        1: b = version[31:24];
        2: b = version[23:16];
        3: b = version[15:8];
        4: b = version[7:0];
        5: b = dcid;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic test_header_fields();
    max_gap = 3;
    stall_pct = 30;
    send_payload(8'hC0, VersionV1, 8'd0, 7);
    send_payload(8'hD5, VersionV2, 8'd8, 15);
    send_payload(8'hCF, VersionDraft29, 8'd4, 12);
    send_payload(8'hC3, VersionDraft32, 8'd1, 9);
    send_payload(8'hC0, VersionDraft33, 8'd20, 27);
    send_payload(8'hC7, VersionDraft34, 8'd0, 7);
    send_payload(8'hD0, VersionV1, 8'd0, 10);
    send_payload(8'hC0, VersionV2, 8'd0, 10);
    send_payload(8'hE0, VersionDraft29, 8'd0, 10);
    send_payload(8'h40, VersionV1, 8'd0, 10);
    send_payload(8'h80, VersionV1, 8'd0, 10);
    send_payload(8'hFF, 32'h0000_0002, 8'd0, 10);
  endtask

  task automatic test_lengths();
    max_gap = 0;
    stall_pct = 0;
    send_payload(8'hC0, VersionV1, 8'd0, 1);
    send_payload(8'hC0, VersionV1, 8'd0, 6);
    send_payload(8'hC0, VersionV1, 8'd20, 26);
    send_payload(8'hC0, VersionV1, 8'd21, 40);
    send_payload(8'hD0, VersionV2, 8'd255, 40);
    send_payload(8'hC0, VersionDraft34, 8'd20, 50);
    send_payload(8'h00, 32'h0, 8'd0, 8);
    send_payload(8'hFF, 32'hFFFF_FFFF, 8'hFF, 33);
  endtask

  task automatic test_backpressure();
    max_gap = 0;
    stall_pct = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    for (int i = 0; i < 12; i++) begin
      send_payload(8'hC0, known_version($urandom_range(0, 5)), 8'($urandom_range(0, 2)), 9);
    end
  endtask

  task automatic test_random_traffic(input int unsigned nbytes, input int unsigned gap,
                                     input int unsigned pct);
    int unsigned stop_at;
    logic [1:0] kind_type;
    logic [7:0] first;
    logic [31:0] version;
    logic [7:0] dcid;
    int unsigned len;
    int unsigned pick;
    stop_at = bytes_sent + nbytes;
    max_gap = gap;
    stall_pct = pct;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 20) begin
        send_payload(8'($urandom), $urandom, 8'($urandom), $urandom_range(1, 40));
      end else begin
        pick = $urandom_range(0, 5);
        version = known_version(pick);
        if ($urandom_range(0, 99) < 5) begin
          version[$urandom_range(0, 31)] ^= 1'b1;
        end
        kind_type = (pick == 1) ? TypeInitialV2 : TypeInitialV1;
        if ($urandom_range(0, 99) < 20) begin
          kind_type = 2'($urandom);
        end
        first = {2'b11, kind_type, 4'($urandom)};
        if ($urandom_range(0, 99) < 10) begin
          first[$urandom_range(6, 7)] = 1'b0;
        end
        dcid = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, MaxDcidLen))
                                             : 8'($urandom_range(MaxDcidLen + 1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          len = 7 + dcid + $urandom_range(0, 12);
          if (len > 48) begin
            len = $urandom_range(30, 48);
          end
        end else if (pick < 90) begin
          len = $urandom_range(1, (dcid > 40) ? 47 : 7 + dcid);
        end else begin
          len = $urandom_range(30, 48);
        end
        send_payload(first, version, dcid, len);
      end
    end
  endtask

  initial begin
    logic stall_now;
    int unsigned run_left;
    out_stall_i = 1'b0;
    run_left = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < stall_pct);
          run_left = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        out_stall_i <= stall_now;
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_verdicts
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no payload outstanding");
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data_o.detected !== want.detected) begin
          report_mismatch($sformatf("detected got %b want %b",
                                    out_data_o.detected, want.detected));
        end
        if (out_data_o.version_kind !== want.version_kind) begin
          report_mismatch($sformatf("version_kind got %0d want %0d",
                                    out_data_o.version_kind, want.version_kind));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_header_fields();
    test_lengths();
    test_backpressure();
    test_random_traffic(RandomBytes / 3, 0, 0);
    test_random_traffic(RandomBytes / 3, 6, 40);
    test_random_traffic(RandomBytes / 3, 2, 75);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
